@@ rtl/core/dhfk_pkg.sv @@
package dhfk_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int CF_BITS          = 30;
  localparam int ATAN_COUNT       = 24;
  localparam int LEN_W            = 24;
  localparam int POS_W            = 32;
  localparam int ANG_W            = 16;
  localparam int CIDX_W           = 3;

  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

  localparam logic [31:0] ATAN_TAB [ATAN_COUNT] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef enum logic [CIDX_W-1:0] {
    CFG_X_MIN = 3'd0,
    CFG_X_MAX = 3'd1,
    CFG_Y_MIN = 3'd2,
    CFG_Y_MAX = 3'd3,
    CFG_Z_MIN = 3'd4,
    CFG_Z_MAX = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [ANG_W-1:0]        theta;
    logic [ANG_W-1:0]        twist;
    logic signed [LEN_W-1:0] r;
    logic signed [LEN_W-1:0] d;
    logic                    last;
  } joint_t;

  typedef struct packed {
    logic                    we;
    logic [CIDX_W-1:0]       index;
    logic signed [POS_W-1:0] data;
  } cfg_wr_t;

endpackage

@@ rtl/core/dhfk_front.sv @@
module dhfk_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [dhfk_pkg::ANG_W-1:0]         joint_angle,
  input  logic [dhfk_pkg::ANG_W-1:0]         theta_offset,
  input  logic [dhfk_pkg::ANG_W-1:0]         link_twist,
  input  logic signed [dhfk_pkg::LEN_W-1:0]  link_length,
  input  logic signed [dhfk_pkg::LEN_W-1:0]  link_offset,
  input  logic                               last_joint,
  output logic                               q_valid,
  input  logic                               q_ready,
  output dhfk_pkg::joint_t                   q_item
);

  dhfk_pkg::joint_t mem [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;
  dhfk_pkg::joint_t item;
  logic             push;
  logic             pop;

  always_comb begin
    item.theta = joint_angle + theta_offset;
    item.twist = link_twist;
    item.r     = link_length;
    item.d     = link_offset;
    item.last  = last_joint;
  end

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = mem[rptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ rtl/core/dhfk_cordic.sv @@
module dhfk_cordic #(
  parameter int STEPS = dhfk_pkg::CORDIC_STEPS_DEF,
  parameter int FRAC  = dhfk_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [dhfk_pkg::ANG_W-1:0]   angle,
  output logic                         done,
  output logic signed [FRAC+1:0]       sin_out,
  output logic signed [FRAC+1:0]       cos_out
);

  localparam int RW = FRAC + 2;
  localparam int XW = 34;
  localparam int ZW = 33;
  localparam int IW = $clog2(STEPS);
  localparam int SH = dhfk_pkg::CF_BITS - FRAC;
  localparam logic signed [XW-1:0] HALF = XW'(64'sd1 <<< (SH - 1));
  localparam logic signed [XW-1:0] ONE  = XW'(64'sd1 <<< FRAC);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} state_t;

  state_t                state;
  logic signed [XW-1:0]  x;
  logic signed [XW-1:0]  y;
  logic signed [ZW-1:0]  z;
  logic [IW-1:0]         cnt;
  logic                  flip;
  logic [31:0]           phi;
  logic signed [ZW-1:0]  at;
  logic signed [XW-1:0]  xs;
  logic signed [XW-1:0]  ys;
  logic signed [XW-1:0]  xr;
  logic signed [XW-1:0]  yr;
  logic signed [XW-1:0]  xc;
  logic signed [XW-1:0]  yc;

  always_comb begin
    phi = {angle, 16'h0000};
    at  = ZW'(signed'({1'b0, dhfk_pkg::ATAN_TAB[5'(cnt)]}));
    xs  = x >>> cnt;
    ys  = y >>> cnt;
    xr  = (x + HALF) >>> SH;
    yr  = (y + HALF) >>> SH;
    xc  = (xr > ONE) ? ONE : ((xr < -ONE) ? -ONE : xr);
    yc  = (yr > ONE) ? ONE : ((yr < -ONE) ? -ONE : yr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            flip  <= (phi[31:30] == 2'b01) || (phi[31:30] == 2'b10);
            z     <= ZW'(signed'({phi[30], phi[30:0]}));
            x     <= XW'(dhfk_pkg::CORDIC_GAIN);
            y     <= '0;
            cnt   <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (!z[ZW-1]) begin
            x <= x - ys;
            y <= y + xs;
            z <= z - at;
          end else begin
            x <= x + ys;
            y <= y - xs;
            z <= z + at;
          end
          cnt <= cnt + 1'b1;
          if (cnt == IW'(STEPS - 1)) state <= S_FIN;
        end
        S_FIN: begin
          cos_out <= flip ? -RW'(xc) : RW'(xc);
          sin_out <= flip ? -RW'(yc) : RW'(yc);
          done    <= 1'b1;
          state   <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/dhfk_back.sv @@
module dhfk_back #(
  parameter int STEPS = dhfk_pkg::CORDIC_STEPS_DEF,
  parameter int FRAC  = dhfk_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  output logic                              q_ready,
  input  dhfk_pkg::joint_t                  q_item,
  input  dhfk_pkg::cfg_wr_t                 cfg,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [dhfk_pkg::POS_W-1:0] pos_x,
  output logic signed [dhfk_pkg::POS_W-1:0] pos_y,
  output logic signed [dhfk_pkg::POS_W-1:0] pos_z,
  output logic                              in_bounds
);

  localparam int RW  = FRAC + 2;
  localparam int BW  = 26;
  localparam int PW  = RW + BW;
  localparam int AW  = PW + 2;
  localparam int PSW = dhfk_pkg::POS_W;
  localparam logic signed [AW-1:0] HALF   = AW'(64'sd1 <<< (FRAC - 1));
  localparam logic signed [AW-1:0] ROT_HI = AW'((64'sd1 <<< (FRAC + 1)) - 1);
  localparam logic signed [AW-1:0] ROT_LO = AW'(-(64'sd1 <<< (FRAC + 1)));
  localparam logic signed [AW-1:0] POS_HI = AW'(64'sd2147483647);
  localparam logic signed [AW-1:0] POS_LO = AW'(-64'sd2147483648);
  localparam logic signed [RW-1:0] ONE_R  = RW'(64'sd1 <<< FRAC);

  typedef enum logic [2:0] {S_IDLE, S_TRIG, S_SINCOS, S_MAC, S_DRAIN, S_COMMIT} state_t;

  state_t state;
  logic signed [RW-1:0]  rot [9];
  logic signed [RW-1:0]  nr  [9];
  logic signed [RW-1:0]  ra  [9];
  logic signed [BW-1:0]  pa  [3];
  logic signed [PSW-1:0] trans [3];
  logic signed [PSW-1:0] np  [3];
  logic signed [PSW-1:0] bnd [6];
  logic signed [dhfk_pkg::LEN_W-1:0] r_len;
  logic signed [dhfk_pkg::LEN_W-1:0] d_len;
  logic last_q;

  logic cstart;
  logic [dhfk_pkg::ANG_W-1:0] ang_t, ang_a;
  logic done_t, done_a;
  logic signed [RW-1:0] st, ct, sa, ca;

  logic       ph;
  logic [2:0] ac;
  logic [1:0] bi, bj, bk;
  logic       pv, t_ph;
  logic [2:0] t_ac;
  logic [1:0] t_i, t_j, t_k;
  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] acc;

  logic signed [RW-1:0] a_op;
  logic signed [BW-1:0] b_op;
  logic signed [AW-1:0] ext, sum, rs, rclamp, tsum, tclamp;
  logic [3:0] ridx, aidx, widx;
  logic issue_last;
  logic ok;

  dhfk_cordic #(.STEPS(STEPS), .FRAC(FRAC)) u_cordic_theta (
    .clk(clk), .rst(rst), .start(cstart), .angle(ang_t),
    .done(done_t), .sin_out(st), .cos_out(ct)
  );

  dhfk_cordic #(.STEPS(STEPS), .FRAC(FRAC)) u_cordic_twist (
    .clk(clk), .rst(rst), .start(cstart), .angle(ang_a),
    .done(done_a), .sin_out(sa), .cos_out(ca)
  );

  assign q_ready = (state == S_IDLE);

  always_comb begin
    ridx = 4'({bi, 1'b0}) + 4'(bi) + 4'(bk);
    aidx = 4'({bk, 1'b0}) + 4'(bk) + 4'(bj);
    widx = 4'({t_i, 1'b0}) + 4'(t_i) + 4'(t_j);
    a_op = '0;
    b_op = '0;
    if (!ph) begin
      unique case (ac)
        3'd0: begin a_op = st; b_op = BW'(ca); end
        3'd1: begin a_op = st; b_op = BW'(sa); end
        3'd2: begin a_op = ct; b_op = BW'(ca); end
        3'd3: begin a_op = ct; b_op = BW'(sa); end
        3'd4: begin a_op = ct; b_op = BW'(r_len); end
        3'd5: begin a_op = st; b_op = BW'(r_len); end
        default: begin a_op = '0; b_op = '0; end
      endcase
    end else begin
      a_op = rot[ridx];
      b_op = (bj == 2'd3) ? pa[bk] : BW'(ra[aidx]);
    end
    issue_last = ph && (bi == 2'd2) && (bj == 2'd3) && (bk == 2'd2);
    ext    = AW'(prod);
    sum    = (!t_ph || t_k == 2'd0) ? ext : acc + ext;
    rs     = (sum + HALF) >>> FRAC;
    rclamp = (rs > ROT_HI) ? ROT_HI : ((rs < ROT_LO) ? ROT_LO : rs);
    tsum   = rs + AW'(trans[t_i]);
    tclamp = (tsum > POS_HI) ? POS_HI : ((tsum < POS_LO) ? POS_LO : tsum);
    ok = (np[0] >= bnd[0]) && (np[0] <= bnd[1]) && (np[1] >= bnd[2]) &&
         (np[1] <= bnd[3]) && (np[2] >= bnd[4]) && (np[2] <= bnd[5]);
  end

  always_ff @(posedge clk) begin
    prod <= a_op * b_op;
    t_ph <= ph;
    t_ac <= ac;
    t_i  <= bi;
    t_j  <= bj;
    t_k  <= bk;
    if (pv) begin
      acc <= sum;
      if (!t_ph) begin
        unique case (t_ac)
          3'd0: ra[1] <= -RW'(rs);
          3'd1: ra[2] <= RW'(rs);
          3'd2: ra[4] <= RW'(rs);
          3'd3: ra[5] <= -RW'(rs);
          3'd4: pa[0] <= BW'(rs);
          3'd5: pa[1] <= BW'(rs);
          default: ;
        endcase
      end else if (t_k == 2'd2) begin
        if (t_j == 2'd3) np[t_i] <= PSW'(tclamp);
        else nr[widx] <= RW'(rclamp);
      end
    end
    if (state == S_IDLE && q_valid) begin
      ang_t  <= q_item.theta;
      ang_a  <= q_item.twist;
      r_len  <= q_item.r;
      d_len  <= q_item.d;
      last_q <= q_item.last;
    end
    if (state == S_SINCOS && done_t && done_a) begin
      ra[0] <= ct;
      ra[3] <= st;
      ra[6] <= '0;
      ra[7] <= sa;
      ra[8] <= ca;
      pa[2] <= BW'(d_len);
    end
    if (state == S_COMMIT && (!last_q || !out_valid || out_ready)) begin
      if (last_q) begin
        pos_x     <= np[0];
        pos_y     <= np[1];
        pos_z     <= np[2];
        in_bounds <= ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cstart    <= 1'b0;
      pv        <= 1'b0;
      out_valid <= 1'b0;
      ph        <= 1'b0;
      ac        <= '0;
      bi        <= '0;
      bj        <= '0;
      bk        <= '0;
      for (int k = 0; k < 9; k++) rot[k] <= (k % 4 == 0) ? ONE_R : '0;
      for (int k = 0; k < 3; k++) trans[k] <= '0;
      bnd[0] <= POS_LO[PSW-1:0];
      bnd[1] <= POS_HI[PSW-1:0];
      bnd[2] <= POS_LO[PSW-1:0];
      bnd[3] <= POS_HI[PSW-1:0];
      bnd[4] <= POS_LO[PSW-1:0];
      bnd[5] <= POS_HI[PSW-1:0];
    end else begin
      cstart <= 1'b0;
      pv     <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg.we) begin
        unique case (cfg.index)
          dhfk_pkg::CFG_X_MIN: bnd[0] <= cfg.data;
          dhfk_pkg::CFG_X_MAX: bnd[1] <= cfg.data;
          dhfk_pkg::CFG_Y_MIN: bnd[2] <= cfg.data;
          dhfk_pkg::CFG_Y_MAX: bnd[3] <= cfg.data;
          dhfk_pkg::CFG_Z_MIN: bnd[4] <= cfg.data;
          dhfk_pkg::CFG_Z_MAX: bnd[5] <= cfg.data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) state <= S_TRIG;
        end
        S_TRIG: begin
          cstart <= 1'b1;
          state  <= S_SINCOS;
        end
        S_SINCOS: begin
          if (done_t && done_a) begin
            ph    <= 1'b0;
            ac    <= '0;
            bi    <= '0;
            bj    <= '0;
            bk    <= '0;
            state <= S_MAC;
          end
        end
        S_MAC: begin
          pv <= 1'b1;
          if (!ph) begin
            ac <= ac + 1'b1;
            if (ac == 3'd5) ph <= 1'b1;
          end else if (issue_last) begin
            state <= S_DRAIN;
          end else if (bk != 2'd2) begin
            bk <= bk + 1'b1;
          end else begin
            bk <= '0;
            if (bj != 2'd3) begin
              bj <= bj + 1'b1;
            end else begin
              bj <= '0;
              bi <= bi + 1'b1;
            end
          end
        end
        S_DRAIN: state <= S_COMMIT;
        S_COMMIT: begin
          if (!last_q) begin
            for (int k = 0; k < 9; k++) rot[k] <= nr[k];
            for (int k = 0; k < 3; k++) trans[k] <= np[k];
            state <= S_IDLE;
          end else if (!out_valid || out_ready) begin
            for (int k = 0; k < 9; k++) rot[k] <= (k % 4 == 0) ? ONE_R : '0;
            for (int k = 0; k < 3; k++) trans[k] <= '0;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/dh_forward_kinematics.sv @@
// The back end works on one joint at a time and takes no new joint until
// the last is committed; its pace is set by the iterative CORDIC and the 42
// multiplies on the single shared multiplier.
// A two-word input queue lets joints arrive while the back end works.
// Reset: synchronous, active high; running transform becomes identity and
// the workspace bounds open to the full signed range.
module dh_forward_kinematics #(
  parameter int CORDIC_STEPS = dhfk_pkg::CORDIC_STEPS_DEF,
  parameter int FRAC_BITS    = dhfk_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [dhfk_pkg::ANG_W-1:0]         joint_angle,
  input  logic [dhfk_pkg::ANG_W-1:0]         theta_offset,
  input  logic [dhfk_pkg::ANG_W-1:0]         link_twist,
  input  logic signed [dhfk_pkg::LEN_W-1:0]  link_length,
  input  logic signed [dhfk_pkg::LEN_W-1:0]  link_offset,
  input  logic                               last_joint,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [dhfk_pkg::POS_W-1:0]  pos_x,
  output logic signed [dhfk_pkg::POS_W-1:0]  pos_y,
  output logic signed [dhfk_pkg::POS_W-1:0]  pos_z,
  output logic                               in_bounds,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dhfk_pkg::CIDX_W-1:0]        cfg_index,
  input  logic signed [dhfk_pkg::POS_W-1:0]  cfg_data
);

  logic              q_valid;
  logic              q_ready;
  dhfk_pkg::joint_t  q_item;
  dhfk_pkg::cfg_wr_t cfg;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg.we    = cfg_valid;
    cfg.index = cfg_index;
    cfg.data  = cfg_data;
  end

  dhfk_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .joint_angle(joint_angle), .theta_offset(theta_offset),
    .link_twist(link_twist), .link_length(link_length),
    .link_offset(link_offset), .last_joint(last_joint),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  dhfk_back #(.STEPS(CORDIC_STEPS), .FRAC(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .cfg(cfg),
    .out_valid(out_valid), .out_ready(out_ready),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .in_bounds(in_bounds)
  );

endmodule
